// ===== hw/rtl/rlrs_pkg.sv =====
// Package for the run length resolution scaler.
// Holds field widths, register indexes, mode codes and shared structs.
// No dependencies.
`timescale 1ns / 1ps

package rlrs_pkg;

  localparam int RUN_W   = 14;
  localparam int OUT_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 14;
  localparam int ALU_W   = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_LONG  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LONG  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_SHORT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_SHORT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH  = 3'd5;

  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_UP   = 2'd1;
  localparam logic [1:0] MODE_DOWN = 2'd2;

  typedef struct packed {
    logic [1:0]  scale_mode;
    logic [3:0]  extra_long;
    logic [3:0]  count_long;
    logic [3:0]  extra_short;
    logic [3:0]  count_short;
    logic [13:0] line_width;
  } cfg_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             ge;
    logic [ALU_W-1:0] diff;
  } alu_rsp_t;

endpackage

// ===== hw/rtl/rlrs_if.sv =====
// Valid/ready channel interfaces for the run length resolution scaler.
// Depends on rlrs_pkg for field widths.
`timescale 1ns / 1ps

interface rlrs_in_if;
  logic                       valid;
  logic                       ready;
  logic [rlrs_pkg::RUN_W-1:0] run_length;

  modport source (output valid, output run_length, input ready);
  modport sink   (input valid, input run_length, output ready);
endinterface

interface rlrs_out_if;
  logic                       valid;
  logic                       ready;
  logic [rlrs_pkg::OUT_W-1:0] scaled_run;
  logic                       line_end;

  modport source (output valid, output scaled_run, output line_end, input ready);
  modport sink   (input valid, input scaled_run, input line_end, output ready);
endinterface

// ===== hw/rtl/run_length_resolution_scaler.sv =====
// Top level of the run length resolution scaler.
// Depends on rlrs_pkg, rlrs_if, rlrs_cfg, rlrs_core and rlrs_alu.
//
// Usage: each transfer on in_chan carries one run of a scan line; each run
// yields exactly one transfer on out_chan with the rescaled run (saturated
// at 65535) and line_end set on the run that completes the line.
// Registers are written through cfg_we/cfg_idx/cfg_wdata while the block is
// idle: a rule for the user, which the block itself does not enforce. A write
// takes effect on the next run.
// Timing: one pixel of the run is processed per clock by the sequencer, with
// one shared compare/subtract unit; pass mode goes straight to the last step.
// The first run after a register write first reduces the counters into the
// new period by repeated subtraction.
// The next run is accepted as soon as the previous result sits in the
// output register, so a stalled receiver holds at most one finished result
// plus one run in progress; the sequencer waits at its last step until the
// output register frees up.
// Reset (synchronous, rst_n low) restores the register defaults and clears
// the slot phase, period position and line sum.
`timescale 1ns / 1ps

module run_length_resolution_scaler (
  input  logic                            clk,
  input  logic                            rst_n,
  rlrs_in_if.sink                         in_chan,
  rlrs_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [rlrs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [rlrs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  rlrs_pkg::cfg_t cfg;

  rlrs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rlrs_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .cfg_we         (cfg_we),
    .in_valid       (in_chan.valid),
    .in_ready       (in_chan.ready),
    .in_run_length  (in_chan.run_length),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_scaled_run (out_chan.scaled_run),
    .out_line_end   (out_chan.line_end)
  );

endmodule

// ===== hw/rtl/rlrs_alu.sv =====
// Shared compare and subtract unit of the scaler sequencer.
// Depends on rlrs_pkg for the request and response structs.
`timescale 1ns / 1ps

module rlrs_alu (
  input  rlrs_pkg::alu_req_t req,
  output rlrs_pkg::alu_rsp_t rsp
);

  assign rsp.ge   = (req.a >= req.b);
  assign rsp.diff = req.a - req.b;

endmodule

// ===== hw/rtl/rlrs_cfg.sv =====
// Configuration register file of the scaler.
// Depends on rlrs_pkg for register indexes and the cfg_t struct.
`timescale 1ns / 1ps

module rlrs_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rlrs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [rlrs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output rlrs_pkg::cfg_t                  cfg
);

  rlrs_pkg::cfg_t cfg_r;
  rlrs_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        rlrs_pkg::CFG_SCALE_MODE:  cfg_nxt.scale_mode  = cfg_wdata[1:0];
        rlrs_pkg::CFG_EXTRA_LONG:  cfg_nxt.extra_long  = cfg_wdata[3:0];
        rlrs_pkg::CFG_COUNT_LONG:  cfg_nxt.count_long  = cfg_wdata[3:0];
        rlrs_pkg::CFG_EXTRA_SHORT: cfg_nxt.extra_short = cfg_wdata[3:0];
        rlrs_pkg::CFG_COUNT_SHORT: cfg_nxt.count_short = cfg_wdata[3:0];
        rlrs_pkg::CFG_LINE_WIDTH:  cfg_nxt.line_width  = cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale_mode  <= rlrs_pkg::MODE_PASS;
      cfg_r.extra_long  <= 4'd0;
      cfg_r.count_long  <= 4'd0;
      cfg_r.extra_short <= 4'd0;
      cfg_r.count_short <= 4'd1;
      cfg_r.line_width  <= 14'd1728;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/rlrs_core.sv =====
// Sequencer and datapath of the scaler: steps one pixel per cycle through a run.
// Depends on rlrs_pkg and the shared compare/subtract unit rlrs_alu.
`timescale 1ns / 1ps

module rlrs_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rlrs_pkg::cfg_t              cfg,
  input  logic                        cfg_we,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rlrs_pkg::RUN_W-1:0]  in_run_length,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rlrs_pkg::OUT_W-1:0]  out_scaled_run,
  output logic                        out_line_end
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_UP_MOD = 4'd1;
  localparam logic [3:0] ST_UP_RUN = 4'd2;
  localparam logic [3:0] ST_DN_MUL = 4'd3;
  localparam logic [3:0] ST_DN_SUM = 4'd4;
  localparam logic [3:0] ST_DN_MOD = 4'd5;
  localparam logic [3:0] ST_DN_ML  = 4'd6;
  localparam logic [3:0] ST_DN_MS  = 4'd7;
  localparam logic [3:0] ST_DN_RUN = 4'd8;
  localparam logic [3:0] ST_FIN    = 4'd9;

  logic [3:0]  state_r, state_nxt;
  logic [13:0] run_r, run_nxt;
  logic [13:0] cnt_r, cnt_nxt;
  logic [17:0] acc_r, acc_nxt;
  logic        last_r, last_nxt;
  logic [14:0] line_sum_r, line_sum_nxt;
  logic [4:0]  phase_r, phase_nxt;
  logic [8:0]  pos_r, pos_nxt;
  logic [8:0]  ml_r, ml_nxt;
  logic [8:0]  ms_r, ms_nxt;
  logic [8:0]  lp_r, lp_nxt;
  logic [8:0]  per_r, per_nxt;
  logic        dirty_r, dirty_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_run_r, out_run_nxt;
  logic        out_end_r, out_end_nxt;

  logic [4:0]  up_period;
  logic [4:0]  gl;
  logic [4:0]  gs;
  logic [14:0] sum_full;
  logic        accept;
  logic        load;
  logic [17:0] result;
  logic        drop;

  rlrs_pkg::alu_req_t alu_req;
  rlrs_pkg::alu_rsp_t alu_rsp;

  rlrs_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign up_period = {1'b0, cfg.count_long} + {1'b0, cfg.count_short};
  assign gl        = {1'b0, cfg.extra_long} + 5'd1;
  assign gs        = {1'b0, cfg.extra_short} + 5'd1;
  assign sum_full  = line_sum_r + {1'b0, in_run_length};

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign load     = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  // Operand selection for the shared unit, one use per state.
  always_comb begin
    case (state_r)
      ST_UP_MOD: begin
        alu_req.a = {4'b0, phase_r};
        alu_req.b = {4'b0, up_period};
      end
      ST_UP_RUN: begin
        alu_req.a = {4'b0, phase_r};
        alu_req.b = {5'b0, cfg.count_long};
      end
      ST_DN_MOD: begin
        alu_req.a = pos_r;
        alu_req.b = per_r;
      end
      ST_DN_ML: begin
        alu_req.a = ml_r;
        alu_req.b = {4'b0, gl};
      end
      ST_DN_MS: begin
        alu_req.a = ms_r;
        alu_req.b = {4'b0, gs};
      end
      default: begin
        alu_req.a = pos_r;
        alu_req.b = lp_r;
      end
    endcase
  end

  // In the short part the drop test uses the absolute position, as specified.
  assign drop = alu_rsp.ge ? (ms_r != 9'd0) : (ml_r != 9'd0);

  always_comb begin
    case (cfg.scale_mode)
      rlrs_pkg::MODE_UP:   result = {4'b0, run_r} + acc_r;
      rlrs_pkg::MODE_DOWN: result = {4'b0, run_r - acc_r[13:0]};
      default:             result = {4'b0, run_r};
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    run_nxt       = run_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    last_nxt      = last_r;
    line_sum_nxt  = line_sum_r;
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    ml_nxt        = ml_r;
    ms_nxt        = ms_r;
    lp_nxt        = lp_r;
    per_nxt       = per_r;
    dirty_nxt     = dirty_r;
    out_valid_nxt = out_valid_r;
    out_run_nxt   = out_run_r;
    out_end_nxt   = out_end_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          run_nxt = in_run_length;
          cnt_nxt = in_run_length;
          acc_nxt = 18'd0;
          if (sum_full >= {1'b0, cfg.line_width}) begin
            last_nxt     = 1'b1;
            line_sum_nxt = 15'd0;
          end else begin
            last_nxt     = 1'b0;
            line_sum_nxt = sum_full;
          end
          case (cfg.scale_mode)
            rlrs_pkg::MODE_UP:   state_nxt = ST_UP_MOD;
            rlrs_pkg::MODE_DOWN: state_nxt = ST_DN_MUL;
            default:             state_nxt = ST_FIN;
          endcase
        end
      end
      ST_UP_MOD: begin
        if (up_period == 5'd0) begin
          phase_nxt = 5'd0;
          state_nxt = ST_FIN;
        end else if (alu_rsp.ge) begin
          phase_nxt = alu_rsp.diff[4:0];
        end else begin
          state_nxt = ST_UP_RUN;
        end
      end
      ST_UP_RUN: begin
        if (cnt_r == 14'd0) begin
          state_nxt = ST_FIN;
        end else begin
          acc_nxt   = acc_r + {14'b0, (alu_rsp.ge ? cfg.extra_short : cfg.extra_long)};
          phase_nxt = (phase_r + 5'd1 == up_period) ? 5'd0 : phase_r + 5'd1;
          cnt_nxt   = cnt_r - 14'd1;
        end
      end
      ST_DN_MUL: begin
        lp_nxt    = {4'b0, gl} * {5'b0, cfg.count_long};
        state_nxt = ST_DN_SUM;
      end
      ST_DN_SUM: begin
        per_nxt   = lp_r + {4'b0, gs} * {5'b0, cfg.count_short};
        state_nxt = ST_DN_MOD;
      end
      ST_DN_MOD: begin
        if (per_r == 9'd0) begin
          pos_nxt   = 9'd0;
          ml_nxt    = 9'd0;
          ms_nxt    = 9'd0;
          state_nxt = ST_FIN;
        end else if (alu_rsp.ge) begin
          pos_nxt = alu_rsp.diff;
        end else if (dirty_r) begin
          // Group remainders are rebuilt only after a register write.
          ml_nxt    = pos_r;
          ms_nxt    = pos_r;
          state_nxt = ST_DN_ML;
        end else begin
          state_nxt = ST_DN_RUN;
        end
      end
      ST_DN_ML: begin
        if (alu_rsp.ge) begin
          ml_nxt = alu_rsp.diff;
        end else begin
          state_nxt = ST_DN_MS;
        end
      end
      ST_DN_MS: begin
        if (alu_rsp.ge) begin
          ms_nxt = alu_rsp.diff;
        end else begin
          dirty_nxt = 1'b0;
          state_nxt = ST_DN_RUN;
        end
      end
      ST_DN_RUN: begin
        if (cnt_r == 14'd0) begin
          state_nxt = ST_FIN;
        end else begin
          acc_nxt = acc_r + {17'b0, drop};
          cnt_nxt = cnt_r - 14'd1;
          if (pos_r + 9'd1 == per_r) begin
            pos_nxt = 9'd0;
            ml_nxt  = 9'd0;
            ms_nxt  = 9'd0;
          end else begin
            pos_nxt = pos_r + 9'd1;
            ml_nxt  = (ml_r + 9'd1 == {4'b0, gl}) ? 9'd0 : ml_r + 9'd1;
            ms_nxt  = (ms_r + 9'd1 == {4'b0, gs}) ? 9'd0 : ms_r + 9'd1;
          end
        end
      end
      ST_FIN: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_run_nxt   = (result[17:16] != 2'b00) ? 16'hFFFF : result[15:0];
          out_end_nxt   = last_r;
          if (last_r) begin
            phase_nxt = 5'd0;
            pos_nxt   = 9'd0;
            ml_nxt    = 9'd0;
            ms_nxt    = 9'd0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cfg_we) begin
      dirty_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      line_sum_r  <= 15'd0;
      phase_r     <= 5'd0;
      pos_r       <= 9'd0;
      ml_r        <= 9'd0;
      ms_r        <= 9'd0;
      dirty_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      line_sum_r  <= line_sum_nxt;
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      ml_r        <= ml_nxt;
      ms_r        <= ms_nxt;
      dirty_r     <= dirty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_r     <= run_nxt;
    cnt_r     <= cnt_nxt;
    acc_r     <= acc_nxt;
    last_r    <= last_nxt;
    lp_r      <= lp_nxt;
    per_r     <= per_nxt;
    out_run_r <= out_run_nxt;
    out_end_r <= out_end_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_scaled_run = out_run_r;
  assign out_line_end   = out_end_r;

  a_up_phase_in_period: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UP_RUN) |-> (phase_r < up_period))
    else $error("slot phase outside its period while stepping pixels");

  a_dn_counters_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DN_RUN) |->
      ((pos_r < per_r) && (ml_r < {4'b0, gl}) && (ms_r < {4'b0, gs})))
    else $error("down counters not reduced while stepping pixels");

  a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (load && last_r) |=> ((phase_r == 5'd0) && (pos_r == 9'd0) && (line_sum_r == 15'd0)))
    else $error("counters not restarted after the last run of a line");

  a_drop_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FIN) && (cfg.scale_mode == rlrs_pkg::MODE_DOWN)) |->
      ((acc_r[17:14] == 4'd0) && (acc_r[13:0] <= run_r)))
    else $error("more pixels dropped than the run holds");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("input ready again right after a transfer");

endmodule
